// File: rtl/dfp_pkg.sv
// Shared types, codes and fixed-point helpers for the 2-D DFP minimizer step.
// Used by every module of the block; depends on nothing.
package dfp_pkg;

	localparam int DW = 32;            // data width
	localparam int FB = 16;            // fraction bits
	localparam int MW = 2 * DW - FB;   // width of a shifted product or a quotient
	localparam int CW = $clog2(MW + 1);

	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] UNIT = DW'(1) << FB;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_GRAD_TOL = 2'd2;

	typedef struct packed {
		logic                 restart;
		logic signed [DW-1:0] grad_x;
		logic signed [DW-1:0] grad_y;
	} dfp_in_t;

	typedef struct packed {
		logic signed [DW-1:0] next_x;
		logic signed [DW-1:0] next_y;
		logic                 converged;
		logic                 degenerate;
	} dfp_out_t;

	typedef enum logic [5:0] {
		S_IDLE, S_INIT, S_YDIFF,
		S_M_H0Y0, S_M_H1Y1, S_A_V0, S_M_H2Y0, S_M_H3Y1, S_A_V1,
		S_M_SXY0, S_M_SYY1, S_A_D1, S_M_Y0V0, S_M_Y1V1, S_A_D2, S_CHK,
		S_M_SS, S_DIV1, S_WAIT1, S_A_HQ, S_M_VV, S_DIV2, S_WAIT2, S_A_HNQ,
		S_M_H0G, S_M_H1G, S_A_S0, S_A_PX, S_M_H2G, S_M_H3G, S_A_S1, S_A_PY,
		S_SQ_GX, S_SQ_GY, S_SQ_TOL, S_FIN
	} dfp_state_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_YDIFF,
		OP_M_H0Y0, OP_M_H1Y1, OP_A_V0, OP_M_H2Y0, OP_M_H3Y1, OP_A_V1,
		OP_M_SXY0, OP_M_SYY1, OP_A_D1, OP_M_Y0V0, OP_M_Y1V1, OP_A_D2, OP_CHK,
		OP_M_SS, OP_DIV1, OP_A_HQ, OP_M_VV, OP_DIV2, OP_A_HNQ,
		OP_M_H0G, OP_M_H1G, OP_A_S0, OP_A_PX, OP_M_H2G, OP_M_H3G, OP_A_S1, OP_A_PY,
		OP_SQ_GX, OP_SQ_GY, OP_SQ_TOL, OP_FIN
	} dfp_op_t;

	typedef struct packed {
		dfp_op_t    op;
		logic [1:0] ij;    // inverse Hessian entry under update, row-major
	} dfp_cmd_t;

	typedef struct packed {
		logic init_req;    // restart or no previous step
		logic degen;       // a DFP denominator is zero
		logic div_done;
		logic out_busy;    // result register full and not taken this cycle
	} dfp_status_t;

	function automatic logic signed [DW-1:0] fx_add(logic signed [DW-1:0] a,
			logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1])
			return s[DW] ? MINV : MAXV;
		return s[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] fx_neg(logic signed [DW-1:0] a);
		return (a == MINV) ? MAXV : -a;
	endfunction

	function automatic logic [DW-1:0] fx_mag(logic signed [DW-1:0] a);
		return a[DW-1] ? (~a + 1'b1) : a;
	endfunction

	// magnitude and sign back to a saturated signed value
	function automatic logic signed [DW-1:0] fx_sat(logic [MW-1:0] m, logic neg);
		if (m[MW-1:DW-1] != '0)
			return neg ? MINV : MAXV;
		return neg ? -m[DW-1:0] : m[DW-1:0];
	endfunction

endpackage

// File: rtl/dfp_quasi_newton_step_2d.sv
// Top level of the 2-D DFP quasi-Newton step block.
// Depends on dfp_pkg, dfp_ctrl, dfp_datapath (and through it dfp_div).
//
// Usage: each input beat on in_valid/in_ready carries the gradient at the
// current point and a restart flag. The block answers every input beat with
// one output beat on out_valid/out_ready: the new point (saturated Q16.16),
// a convergence flag (squared gradient norm at most the squared tolerance)
// and a degenerate flag (DFP update skipped on a zero denominator).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 start_x,
// 1 start_y, 2 grad_tolerance); write only while the block idles.
// Timing: a restart or first item takes the shortest path, a skipped update a
// longer one; with the DFP update the time is set by the eight quotients
// of the rank-two update, each from a one-bit-per-cycle divider over 48 bits.
// The sequencer can take the next beat in the cycle after an item's last step.
// One item is in work at a time; in_ready is high while the sequencer idles,
// even if the previous result still waits in the output register.
// A stalled receiver holds the output beat; a following item then waits at
// its last step until that beat is taken.
// Reset: point and step cleared, inverse Hessian set to identity, no previous
// step, start registers zero and tolerance 65.
module dfp_quasi_newton_step_2d import dfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [DW-1:0] cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  dfp_in_t       in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output dfp_out_t      out_data
);

	dfp_cmd_t    cmd;
	dfp_status_t sts;

	dfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dfp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/dfp_div.sv
// Restoring divider for fixed-point quotients (a << FB) / b, one bit a cycle.
// Depends on dfp_pkg.
module dfp_div import dfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 busy,
	output logic                 done,
	output logic signed [DW-1:0] quo
);

	logic [MW-1:0] num_q;
	logic [MW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   r2;
	logic          ge;

	assign r2 = {rem_q, num_q[MW-1]};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start)
				cnt_q <= CW'(MW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {fx_mag(num), {FB{1'b0}}};
			den_q <= fx_mag(den);
			neg_q <= num[DW-1] ^ den[DW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[MW-2:0], ge};
			rem_q <= ge ? DW'(r2 - {1'b0, den_q}) : r2[DW-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign quo = fx_sat(quo_q, neg_q);

endmodule

// File: rtl/dfp_ctrl.sv
// Sequencer for the DFP step: walks the datapath through one item's operations.
// Depends on dfp_pkg.
module dfp_ctrl import dfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  dfp_status_t sts,
	output dfp_cmd_t    cmd
);

	dfp_state_t state_q, state_d;
	logic [1:0] ij_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ij_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHK)
				ij_q <= '0;
			else if (state_q == S_A_HNQ)
				ij_q <= ij_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = sts.init_req ? S_INIT : S_YDIFF;
			S_INIT:   state_d = S_M_H0G;
			S_YDIFF:  state_d = S_M_H0Y0;
			S_M_H0Y0: state_d = S_M_H1Y1;
			S_M_H1Y1: state_d = S_A_V0;
			S_A_V0:   state_d = S_M_H2Y0;
			S_M_H2Y0: state_d = S_M_H3Y1;
			S_M_H3Y1: state_d = S_A_V1;
			S_A_V1:   state_d = S_M_SXY0;
			S_M_SXY0: state_d = S_M_SYY1;
			S_M_SYY1: state_d = S_A_D1;
			S_A_D1:   state_d = S_M_Y0V0;
			S_M_Y0V0: state_d = S_M_Y1V1;
			S_M_Y1V1: state_d = S_A_D2;
			S_A_D2:   state_d = S_CHK;
			S_CHK:    state_d = sts.degen ? S_M_H0G : S_M_SS;
			S_M_SS:   state_d = S_DIV1;
			S_DIV1:   state_d = S_WAIT1;
			S_WAIT1:  if (sts.div_done) state_d = S_A_HQ;
			S_A_HQ:   state_d = S_M_VV;
			S_M_VV:   state_d = S_DIV2;
			S_DIV2:   state_d = S_WAIT2;
			S_WAIT2:  if (sts.div_done) state_d = S_A_HNQ;
			S_A_HNQ:  state_d = (ij_q == 2'd3) ? S_M_H0G : S_M_SS;
			S_M_H0G:  state_d = S_M_H1G;
			S_M_H1G:  state_d = S_A_S0;
			S_A_S0:   state_d = S_A_PX;
			S_A_PX:   state_d = S_M_H2G;
			S_M_H2G:  state_d = S_M_H3G;
			S_M_H3G:  state_d = S_A_S1;
			S_A_S1:   state_d = S_A_PY;
			S_A_PY:   state_d = S_SQ_GX;
			S_SQ_GX:  state_d = S_SQ_GY;
			S_SQ_GY:  state_d = S_SQ_TOL;
			S_SQ_TOL: state_d = S_FIN;
			S_FIN:    if (!sts.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.ij = ij_q;
		case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_INIT:   cmd.op = OP_INIT;
			S_YDIFF:  cmd.op = OP_YDIFF;
			S_M_H0Y0: cmd.op = OP_M_H0Y0;
			S_M_H1Y1: cmd.op = OP_M_H1Y1;
			S_A_V0:   cmd.op = OP_A_V0;
			S_M_H2Y0: cmd.op = OP_M_H2Y0;
			S_M_H3Y1: cmd.op = OP_M_H3Y1;
			S_A_V1:   cmd.op = OP_A_V1;
			S_M_SXY0: cmd.op = OP_M_SXY0;
			S_M_SYY1: cmd.op = OP_M_SYY1;
			S_A_D1:   cmd.op = OP_A_D1;
			S_M_Y0V0: cmd.op = OP_M_Y0V0;
			S_M_Y1V1: cmd.op = OP_M_Y1V1;
			S_A_D2:   cmd.op = OP_A_D2;
			S_CHK:    cmd.op = OP_CHK;
			S_M_SS:   cmd.op = OP_M_SS;
			S_DIV1:   cmd.op = OP_DIV1;
			S_A_HQ:   cmd.op = OP_A_HQ;
			S_M_VV:   cmd.op = OP_M_VV;
			S_DIV2:   cmd.op = OP_DIV2;
			S_A_HNQ:  cmd.op = OP_A_HNQ;
			S_M_H0G:  cmd.op = OP_M_H0G;
			S_M_H1G:  cmd.op = OP_M_H1G;
			S_A_S0:   cmd.op = OP_A_S0;
			S_A_PX:   cmd.op = OP_A_PX;
			S_M_H2G:  cmd.op = OP_M_H2G;
			S_M_H3G:  cmd.op = OP_M_H3G;
			S_A_S1:   cmd.op = OP_A_S1;
			S_A_PY:   cmd.op = OP_A_PY;
			S_SQ_GX:  cmd.op = OP_SQ_GX;
			S_SQ_GY:  cmd.op = OP_SQ_GY;
			S_SQ_TOL: cmd.op = OP_SQ_TOL;
			S_FIN:    cmd.op = sts.out_busy ? OP_NONE : OP_FIN;
			default:  cmd.op = OP_NONE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;

endmodule

// File: rtl/dfp_datapath.sv
// Datapath of the DFP step: state registers, shared multiplier, saturating adders,
// divider instance and result register. Depends on dfp_pkg and dfp_div.
module dfp_datapath import dfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [DW-1:0] cfg_data,
	input  dfp_in_t     in_data,
	input  dfp_cmd_t    cmd,
	output dfp_status_t sts,
	output logic        out_valid,
	input  logic        out_ready,
	output dfp_out_t    out_data
);

	logic signed [DW-1:0] start_x_q, start_y_q;
	logic [DW-2:0]        tol_q;
	logic signed [DW-1:0] px_q, py_q, pgx_q, pgy_q, sx_q, sy_q;
	logic signed [DW-1:0] h_q [4];
	logic                 hp_q;
	logic signed [DW-1:0] gx_q, gy_q, y0_q, y1_q, v0_q, v1_q, d1_q, d2_q;
	logic signed [DW-1:0] p_q, t_q;
	logic [2*DW:0]        acc_q;
	logic [2*DW-1:0]      tt_q;
	logic                 deg_q;
	logic                 ov_q;
	dfp_out_t             out_q;

	logic signed [DW-1:0] sa, sb, si, sj, vi, vj;
	logic [DW-1:0]        ma, mb;
	logic [2*DW-1:0]      raw;
	logic signed [DW-1:0] prod, dot, div_q;
	logic                 div_busy, div_done, div_start;

	assign si = cmd.ij[1] ? sy_q : sx_q;
	assign sj = cmd.ij[0] ? sy_q : sx_q;
	assign vi = cmd.ij[1] ? v1_q : v0_q;
	assign vj = cmd.ij[0] ? v1_q : v0_q;

	always_comb begin
		sa = '0;
		sb = '0;
		case (cmd.op)
			OP_M_H0Y0: begin sa = h_q[0]; sb = y0_q; end
			OP_M_H1Y1: begin sa = h_q[1]; sb = y1_q; end
			OP_M_H2Y0: begin sa = h_q[2]; sb = y0_q; end
			OP_M_H3Y1: begin sa = h_q[3]; sb = y1_q; end
			OP_M_SXY0: begin sa = sx_q; sb = y0_q; end
			OP_M_SYY1: begin sa = sy_q; sb = y1_q; end
			OP_M_Y0V0: begin sa = y0_q; sb = v0_q; end
			OP_M_Y1V1: begin sa = y1_q; sb = v1_q; end
			OP_M_SS:   begin sa = si; sb = sj; end
			OP_M_VV:   begin sa = vi; sb = vj; end
			OP_M_H0G:  begin sa = h_q[0]; sb = gx_q; end
			OP_M_H1G:  begin sa = h_q[1]; sb = gy_q; end
			OP_M_H2G:  begin sa = h_q[2]; sb = gx_q; end
			OP_M_H3G:  begin sa = h_q[3]; sb = gy_q; end
			OP_SQ_GX:  begin sa = gx_q; sb = gx_q; end
			OP_SQ_GY:  begin sa = gy_q; sb = gy_q; end
			default: ;
		endcase
	end

	// tolerance is unsigned, so it bypasses the magnitude step
	assign ma = (cmd.op == OP_SQ_TOL) ? {1'b0, tol_q} : fx_mag(sa);
	assign mb = (cmd.op == OP_SQ_TOL) ? {1'b0, tol_q} : fx_mag(sb);
	assign raw = ma * mb;
	assign prod = fx_sat(raw[2*DW-1:FB], sa[DW-1] ^ sb[DW-1]);
	assign dot = fx_add(t_q, p_q);

	assign div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);

	dfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    ((cmd.op == OP_DIV2) ? d2_q : d1_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			tol_q <= (DW-1)'(65);
			px_q <= '0;
			py_q <= '0;
			pgx_q <= '0;
			pgy_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			h_q[0] <= UNIT;
			h_q[1] <= '0;
			h_q[2] <= '0;
			h_q[3] <= UNIT;
			hp_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X:  start_x_q <= cfg_data;
					REG_START_Y:  start_y_q <= cfg_data;
					REG_GRAD_TOL: tol_q <= cfg_data[DW-2:0];
					default: ;
				endcase
			end
			if (out_ready)
				ov_q <= 1'b0;
			case (cmd.op)
				OP_INIT: begin
					px_q <= start_x_q;
					py_q <= start_y_q;
					h_q[0] <= UNIT;
					h_q[1] <= '0;
					h_q[2] <= '0;
					h_q[3] <= UNIT;
				end
				OP_A_HQ:  h_q[cmd.ij] <= fx_add(h_q[cmd.ij], div_q);
				OP_A_HNQ: h_q[cmd.ij] <= fx_add(h_q[cmd.ij], fx_neg(div_q));
				OP_A_S0:  sx_q <= fx_neg(dot);
				OP_A_PX:  px_q <= fx_add(px_q, sx_q);
				OP_A_S1:  sy_q <= fx_neg(dot);
				OP_A_PY:  py_q <= fx_add(py_q, sy_q);
				OP_FIN: begin
					pgx_q <= gx_q;
					pgy_q <= gy_q;
					hp_q <= 1'b1;
					ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				gx_q <= in_data.grad_x;
				gy_q <= in_data.grad_y;
				deg_q <= 1'b0;
			end
			OP_YDIFF: begin
				y0_q <= fx_add(gx_q, fx_neg(pgx_q));
				y1_q <= fx_add(gy_q, fx_neg(pgy_q));
			end
			OP_A_V0: v0_q <= dot;
			OP_A_V1: v1_q <= dot;
			OP_A_D1: d1_q <= dot;
			OP_A_D2: d2_q <= dot;
			OP_CHK:  deg_q <= sts.degen;
			OP_SQ_GX: acc_q <= {1'b0, raw};
			OP_SQ_GY: acc_q <= acc_q + {1'b0, raw};
			OP_SQ_TOL: tt_q <= raw;
			OP_FIN: begin
				out_q.next_x <= px_q;
				out_q.next_y <= py_q;
				out_q.converged <= acc_q <= {1'b0, tt_q};
				out_q.degenerate <= deg_q;
			end
			default: ;
		endcase
		// each product shifts the previous one down for the following add
		case (cmd.op)
			OP_M_H0Y0, OP_M_H1Y1, OP_M_H2Y0, OP_M_H3Y1, OP_M_SXY0, OP_M_SYY1,
			OP_M_Y0V0, OP_M_Y1V1, OP_M_SS, OP_M_VV, OP_M_H0G, OP_M_H1G,
			OP_M_H2G, OP_M_H3G: begin
				t_q <= p_q;
				p_q <= prod;
			end
			default: ;
		endcase
	end

	assign sts.init_req = in_data.restart || !hp_q;
	assign sts.degen = (d1_q == '0) || (d2_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_busy = ov_q && !out_ready;

	assign out_valid = ov_q;
	assign out_data = out_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIN) |-> (!ov_q || out_ready))
		else $error("result beat overwritten before it was taken");
	a_ov_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(cmd.op == OP_FIN))
		else $error("result valid without a finished item");

endmodule

// File: dv/dfp_step_checker.sv
// Checker for the 2-D DFP step block: watches both channels, predicts each
// result from its own copy of the block state and compares field by field.
// Depends on dfp_pkg.
module dfp_step_checker import dfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [DW-1:0] cfg_data,
	input  logic          in_valid,
	input  logic          in_ready,
	input  dfp_in_t       in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  dfp_out_t      out_data,
	output int            errors,
	output int            pending
);

	typedef logic signed [DW-1:0] val_t;

	val_t        st_x, st_y;
	logic [DW-2:0] tol;
	val_t        pos [2];
	val_t        hinv [4];
	val_t        gprev [2];
	val_t        lstep [2];
	bit          have_prev;
	dfp_out_t    expected_q [$];

	assign pending = expected_q.size();

	function automatic val_t sat_mag(logic [127:0] m, bit neg);
		if (m > 128'(MAXV))
			return neg ? MINV : MAXV;
		return neg ? -val_t'(m) : val_t'(m);
	endfunction

	function automatic logic [127:0] magw(val_t a);
		return a[DW-1] ? 128'(-64'(signed'(a))) : 128'(a);
	endfunction

	function automatic val_t qmul(val_t a, val_t b);
		return sat_mag((magw(a) * magw(b)) >> FB, a[DW-1] != b[DW-1]);
	endfunction

	function automatic val_t qdiv(val_t a, val_t b);
		if (b == 0)
			return 0;
		return sat_mag((magw(a) << FB) / magw(b), a[DW-1] != b[DW-1]);
	endfunction

	function automatic val_t qadd(val_t a, val_t b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(MAXV))
			return MAXV;
		if (s < longint'(MINV))
			return MINV;
		return val_t'(s);
	endfunction

	function automatic val_t qneg(val_t a);
		return a == MINV ? MAXV : -a;
	endfunction

	function automatic val_t qdot(val_t a0, val_t a1, val_t b0, val_t b1);
		return qadd(qmul(a0, b0), qmul(a1, b1));
	endfunction

	task automatic reset_hessian();
		hinv[0] = UNIT;
		hinv[1] = 0;
		hinv[2] = 0;
		hinv[3] = UNIT;
	endtask

	task automatic predict_step(dfp_in_t item);
		val_t g [2];
		val_t y [2];
		val_t v [2];
		val_t s [2];
		val_t d1, d2, h, sx, sy;
		dfp_out_t r;
		logic [127:0] nrm;
		g[0] = item.grad_x;
		g[1] = item.grad_y;
		r.degenerate = 1'b0;
		if (item.restart || !have_prev) begin
			pos[0] = st_x;
			pos[1] = st_y;
			reset_hessian();
		end else begin
			s = lstep;
			y[0] = qadd(g[0], qneg(gprev[0]));
			y[1] = qadd(g[1], qneg(gprev[1]));
			v[0] = qdot(hinv[0], hinv[1], y[0], y[1]);
			v[1] = qdot(hinv[2], hinv[3], y[0], y[1]);
			d1 = qdot(s[0], s[1], y[0], y[1]);
			d2 = qdot(y[0], y[1], v[0], v[1]);
			if (d1 == 0 || d2 == 0) begin
				r.degenerate = 1'b1;
			end else begin
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 2; j++) begin
						h = hinv[i*2+j];
						h = qadd(h, qdiv(qmul(s[i], s[j]), d1));
						h = qadd(h, qneg(qdiv(qmul(v[i], v[j]), d2)));
						hinv[i*2+j] = h;
					end
			end
		end
		sx = qneg(qdot(hinv[0], hinv[1], g[0], g[1]));
		sy = qneg(qdot(hinv[2], hinv[3], g[0], g[1]));
		pos[0] = qadd(pos[0], sx);
		pos[1] = qadd(pos[1], sy);
		lstep[0] = sx;
		lstep[1] = sy;
		gprev = g;
		have_prev = 1;
		nrm = magw(g[0]) * magw(g[0]) + magw(g[1]) * magw(g[1]);
		r.next_x = pos[0];
		r.next_y = pos[1];
		r.converged = nrm <= 128'(tol) * 128'(tol);
		expected_q.push_back(r);
	endtask

	task automatic report(string what, logic [DW-1:0] got, logic [DW-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dfp_out_t e;
		if (!arst_n) begin
			st_x = 0;
			st_y = 0;
			tol = 65;
			pos = '{0, 0};
			gprev = '{0, 0};
			lstep = '{0, 0};
			have_prev = 0;
			reset_hessian();
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X: st_x = cfg_data;
					REG_START_Y: st_y = cfg_data;
					REG_GRAD_TOL: tol = cfg_data[DW-2:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_step(in_data);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected beat", out_data.next_x, '0);
				end else begin
					e = expected_q.pop_front();
					if (out_data.next_x !== e.next_x)
						report("next_x", out_data.next_x, e.next_x);
					if (out_data.next_y !== e.next_y)
						report("next_y", out_data.next_y, e.next_y);
					if (out_data.converged !== e.converged)
						report("converged", out_data.converged, e.converged);
					if (out_data.degenerate !== e.degenerate)
						report("degenerate", out_data.degenerate, e.degenerate);
				end
			end
		end
	end

endmodule

// File: dv/dfp_quasi_newton_step_2d_tb.sv
// Testbench top for the 2-D DFP step block: clock, reset, configuration
// phases, directed and random gradient beats, random stalls and the verdict.
// Depends on dfp_pkg, dfp_step_checker and the block's RTL.
module dfp_quasi_newton_step_2d_tb;
	import dfp_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 800;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          cfg_we = 0;
	logic [1:0]    cfg_index = REG_START_X;
	logic [DW-1:0] cfg_data = '0;
	logic          in_valid = 0;
	logic          in_ready;
	dfp_in_t       in_data = '0;
	logic          out_valid;
	logic          out_ready = 0;
	dfp_out_t      out_data;
	int            errors;
	int            pending;
	int            idle_cycles = 0;
	bit            stall_on = 0;

	always #4 clk = ~clk;

	dfp_quasi_newton_step_2d i_dut (.*);

	dfp_step_checker i_chk (.*);

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: stall pattern, phases of heavy and light stalling
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_on <= ~stall_on;
		out_ready <= stall_on ? ($urandom_range(0, 3) == 0)
			: ($urandom_range(0, 7) != 0);
	end

	function automatic logic [DW-1:0] rand_val();
		case ($urandom_range(0, 5))
			0: return MAXV;
			1: return MINV;
			2: return $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 1 << 20);
			3: return $urandom_range(0, 1 << 18);
			4: return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(bit rst, logic [DW-1:0] gx, logic [DW-1:0] gy);
		in_data.restart <= rst;
		in_data.grad_x <= gx;
		in_data.grad_y <= gy;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drop_valid_maybe();
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 30);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DW-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	initial begin
		int k;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset config first, then extremes
		send_beat(0, 32'h0001_0000, 32'hFFFF_0000);
		send_beat(0, 32'h0002_0000, 32'hFFFE_0000);
		send_beat(0, 0, 0);
		send_beat(0, 0, 0);
		send_beat(1, MAXV, MINV);
		send_beat(0, MINV, MAXV);
		send_beat(0, MAXV, MAXV);
		send_beat(1, 65, 0);
		send_beat(0, 66, 0);
		wait_drained();
		write_reg(REG_START_X, MAXV);
		write_reg(REG_START_Y, MINV);
		write_reg(REG_GRAD_TOL, 32'h7FFF_FFFF);
		send_beat(1, 32'h8000_0000, 32'h8000_0000);
		send_beat(0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(0, 32'h0000_0001, 32'hFFFF_FFFF);
		send_beat(1, 32'hFFFF_FFFF, 32'h0000_0001);
		send_beat(0, 32'h0010_0000, 32'h0000_8000);
		wait_drained();
		write_reg(REG_GRAD_TOL, 0);
		write_reg(REG_START_X, 0);
		write_reg(REG_START_Y, 32'h0003_0000);
		send_beat(1, 0, 0);
		send_beat(0, 32'h0001_0000, 0);
		send_beat(0, 32'h0001_0000, 0);
		wait_drained();

		// random: restarts begin short runs of mostly small gradients
		k = 0;
		while (k < N_RANDOM) begin
			if (k % 200 == 199) begin
				wait_drained();
				write_reg(REG_START_X, rand_val());
				write_reg(REG_START_Y, rand_val());
				write_reg(REG_GRAD_TOL, $urandom_range(0, 3) == 0 ? $urandom
					: $urandom_range(0, 1 << 18));
			end
			if ($urandom_range(0, 9) == 0)
				send_beat($urandom_range(0, 1) == 1, rand_val(), rand_val());
			else
				send_beat($urandom_range(0, 11) == 0,
					$signed($urandom_range(0, 1 << 19)) - (1 << 18),
					$signed($urandom_range(0, 1 << 19)) - (1 << 18));
			drop_valid_maybe();
			k++;
		end
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/dfp_pkg.sv
rtl/dfp_div.sv
rtl/dfp_ctrl.sv
rtl/dfp_datapath.sv
rtl/dfp_quasi_newton_step_2d.sv
dv/dfp_step_checker.sv
dv/dfp_quasi_newton_step_2d_tb.sv
